// ----- rtl/spnctr_pkg.sv -----
// shared types, constants and the gf(2^8) product for the spn counter-mode keystream block
// no dependencies; used by every module under rtl except spnctr_ram
package spnctr_pkg;

  localparam int ROUND_COUNT_DEF = 5;
  localparam int SBOX_SLOTS_DEF  = 4;

  localparam int LANES     = 16;
  localparam int OPCODE_W  = 3;
  localparam int TADDR_W   = 10;
  localparam int BYTES_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [OPCODE_W-1:0] OP_SBOX   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MATRIX = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_KEY    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_START  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DATA   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_RAW    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SBOX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY  = 2'd3;

  localparam logic [8:0] POLY_RESET = 9'd283;
  localparam logic [BYTES_W-1:0] FULL_BLOCK = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_MIX,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic sub;
    logic mix;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic cipher_req;
    logic last_round;
    logic out_free;
  } status_t;

  // shift-and-add product, reduction by the low byte of the polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'd0;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ red) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// ----- rtl/spnctr_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module spnctr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/spnctr_ctrl.sv -----
// sequencer for the round loop: idle, substitute, mix, finish
// depends on spnctr_pkg; drives the datapath through spnctr_pkg::cmd_t
module spnctr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spnctr_pkg::status_t  status,
  output spnctr_pkg::cmd_t     cmd
);

  spnctr_pkg::state_t state;
  spnctr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spnctr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spnctr_pkg::ST_IDLE: begin
        if (in_valid && status.cipher_req) begin
          state_next = spnctr_pkg::ST_SUB;
        end
      end
      spnctr_pkg::ST_SUB: begin
        state_next = spnctr_pkg::ST_MIX;
      end
      spnctr_pkg::ST_MIX: begin
        state_next = status.last_round ? spnctr_pkg::ST_FIN : spnctr_pkg::ST_SUB;
      end
      spnctr_pkg::ST_FIN: begin
        if (status.out_free) begin
          state_next = spnctr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spnctr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.sub    = 1'b0;
    cmd.mix    = 1'b0;
    cmd.fin    = 1'b0;
    case (state)
      spnctr_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      spnctr_pkg::ST_SUB: begin
        cmd.sub = 1'b1;
      end
      spnctr_pkg::ST_MIX: begin
        cmd.mix = 1'b1;
      end
      spnctr_pkg::ST_FIN: begin
        cmd.fin = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/spnctr_datapath.sv -----
// tables, counter, round state and output register of the keystream block
// depends on spnctr_pkg and spnctr_ram
module spnctr_datapath #(
  parameter int ROUND_COUNT = spnctr_pkg::ROUND_COUNT_DEF,
  parameter int SBOX_SLOTS  = spnctr_pkg::SBOX_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spnctr_pkg::cmd_t                   cmd,
  output spnctr_pkg::status_t                status,
  input  logic                               cfg_valid,
  input  logic [spnctr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spnctr_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic [spnctr_pkg::OPCODE_W-1:0]    opcode,
  input  logic [spnctr_pkg::TADDR_W-1:0]     table_address,
  input  logic [7:0]                         table_byte,
  input  logic [63:0]                        block_high,
  input  logic [63:0]                        block_low,
  input  logic [spnctr_pkg::BYTES_W-1:0]     valid_bytes,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [63:0]                        out_high,
  output logic [63:0]                        out_low,
  output logic [spnctr_pkg::BYTES_W-1:0]     out_bytes
);

  localparam int SB_DEPTH = SBOX_SLOTS * 256;
  localparam int SB_AW    = $clog2(SB_DEPTH);
  localparam int KEY_ROWS = ROUND_COUNT + 1;
  localparam int KR_AW    = $clog2(KEY_ROWS);
  localparam int L        = spnctr_pkg::LANES;

  logic [63:0] nonce_value;
  logic [63:0] start_count;
  logic [1:0]  sbox_choice;
  logic [8:0]  field_polynomial;
  logic [63:0] block_counter;

  logic [7:0] matrix [L*L];
  logic [7:0] st [L];
  logic [7:0] mixed [L];
  logic [127:0] data;
  logic [spnctr_pkg::BYTES_W-1:0] nbytes;
  logic raw;
  logic [KR_AW-1:0] round;

  logic [7:0] kdata [L];
  logic [7:0] sdata [L];
  logic [1:0] slot_mod;
  logic [spnctr_pkg::BYTES_W-1:0] n_sat;
  logic [127:0] blk_in;
  logic [127:0] cb;
  logic out_free;
  logic key_we;
  logic sb_we;
  logic [KR_AW-1:0] key_raddr;
  logic [127:0] out_word;

  assign n_sat  = (valid_bytes > spnctr_pkg::FULL_BLOCK) ? spnctr_pkg::FULL_BLOCK : valid_bytes;
  assign blk_in = {block_high, block_low};
  assign cb     = {nonce_value, block_counter};
  assign out_free = !out_valid || out_ready;

  assign status.cipher_req = (opcode == spnctr_pkg::OP_RAW) ||
                             ((opcode == spnctr_pkg::OP_DATA) && (valid_bytes != '0));
  assign status.last_round = (32'(round) == ROUND_COUNT - 1);
  assign status.out_free   = out_free;

  assign key_we = cmd.accept && (opcode == spnctr_pkg::OP_KEY) &&
                  (32'(table_address) < KEY_ROWS * L);
  assign sb_we  = cmd.accept && (opcode == spnctr_pkg::OP_SBOX) &&
                  (32'(table_address) < SB_DEPTH);
  // row 0 on load, next row (whitening after the last round) while substituting
  assign key_raddr = cmd.sub ? KR_AW'(round + 1'b1) : '0;

  // slot wraps modulo the number of slots
  always_comb begin
    slot_mod = sbox_choice;
    for (int k = 0; k < 3; k++) begin
      if (32'(slot_mod) >= SBOX_SLOTS) begin
        slot_mod = slot_mod - 2'(SBOX_SLOTS);
      end
    end
  end

  for (genvar g = 0; g < L; g++) begin : g_lane
    spnctr_ram #(
      .WIDTH(8),
      .DEPTH(KEY_ROWS)
    ) u_key (
      .clk  (clk),
      .we   (key_we && (32'(table_address[3:0]) == g)),
      .waddr(KR_AW'(table_address[spnctr_pkg::TADDR_W-1:4])),
      .wdata(table_byte),
      .re   (cmd.accept || cmd.sub),
      .raddr(key_raddr),
      .rdata(kdata[g])
    );

    spnctr_ram #(
      .WIDTH(8),
      .DEPTH(SB_DEPTH)
    ) u_sbox (
      .clk  (clk),
      .we   (sb_we),
      .waddr(SB_AW'(table_address)),
      .wdata(table_byte),
      .re   (cmd.sub),
      .raddr(SB_AW'({slot_mod, st[g] ^ kdata[g]})),
      .rdata(sdata[g])
    );
  end

  always_comb begin
    for (int i = 0; i < L; i++) begin
      mixed[i] = 8'd0;
      for (int j = 0; j < L; j++) begin
        mixed[i] = mixed[i] ^
                   spnctr_pkg::gf_mul(matrix[i*L+j], sdata[j], field_polynomial[7:0]);
      end
    end
  end

  // keystream into the data, bytes past the count cleared; raw: keystream alone
  always_comb begin
    for (int i = 0; i < L; i++) begin
      if (raw) begin
        out_word[127-8*i -: 8] = st[i] ^ kdata[i];
      end else if (5'(i) < nbytes) begin
        out_word[127-8*i -: 8] = data[127-8*i -: 8] ^ st[i] ^ kdata[i];
      end else begin
        out_word[127-8*i -: 8] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_value      <= '0;
      start_count      <= '0;
      sbox_choice      <= '0;
      field_polynomial <= spnctr_pkg::POLY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        spnctr_pkg::CFG_NONCE: nonce_value      <= cfg_data;
        spnctr_pkg::CFG_START: start_count      <= cfg_data;
        spnctr_pkg::CFG_SBOX:  sbox_choice      <= cfg_data[1:0];
        spnctr_pkg::CFG_POLY:  field_polynomial <= cfg_data[8:0];
        default: sbox_choice <= sbox_choice;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (cmd.accept) begin
      if (opcode == spnctr_pkg::OP_START) begin
        block_counter <= start_count;
      end else if ((opcode == spnctr_pkg::OP_DATA) && (valid_bytes != '0)) begin
        block_counter <= block_counter + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (opcode == spnctr_pkg::OP_MATRIX) && (table_address[9:8] == 2'b00)) begin
      matrix[table_address[7:0]] <= table_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < L; i++) begin
        st[i] <= (opcode == spnctr_pkg::OP_RAW) ? blk_in[127-8*i -: 8] : cb[127-8*i -: 8];
      end
      data   <= blk_in;
      nbytes <= n_sat;
      raw    <= (opcode == spnctr_pkg::OP_RAW);
    end else if (cmd.mix) begin
      for (int i = 0; i < L; i++) begin
        st[i] <= mixed[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (cmd.accept) begin
      round <= '0;
    end else if (cmd.mix) begin
      round <= round + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_high  <= out_word[127:64];
      out_low   <= out_word[63:0];
      out_bytes <= raw ? spnctr_pkg::FULL_BLOCK : nbytes;
    end
  end

endmodule

// ----- rtl/spn_cipher_ctr_keystream.sv -----
// spn block cipher in counter mode: input request channel, result channel, register port
// depends on spnctr_pkg, spnctr_ctrl, spnctr_datapath
//
// requests on the input channel (in_valid/in_ready) either load a table byte
// (s-box, mixing matrix, round key), restart the block counter, process a
// data block or encipher a raw block. table writes and counter restarts
// produce no result. a data block with a nonzero byte count and a raw block
// each produce one result on out_valid/out_ready.
// a cipher request runs ROUND_COUNT rounds, each a key add and s-box read,
// then the 16x16 gf matrix product, and then adds the whitening key as the
// result is registered, waiting for the output register to be free; the
// next request is taken the cycle after the result is registered. the
// s-box and round keys sit in 16 lane rams each, so all sixteen bytes are
// substituted in one read.
// the output register holds a result while the receiver stalls; further table
// writes are still taken then, and a following cipher request finishes and
// waits until the held result has gone.
// registers must be written on cfg_valid only while the block is idle; the
// block does not enforce this. reset clears the counter, the handshake state
// and the registers (the polynomial goes to 283); tables are undefined until loaded.
module spn_cipher_ctr_keystream #(
  parameter int ROUND_COUNT = spnctr_pkg::ROUND_COUNT_DEF,
  parameter int SBOX_SLOTS  = spnctr_pkg::SBOX_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spnctr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spnctr_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [spnctr_pkg::OPCODE_W-1:0]    opcode,
  input  logic [spnctr_pkg::TADDR_W-1:0]     table_address,
  input  logic [7:0]                         table_byte,
  input  logic [63:0]                        block_high,
  input  logic [63:0]                        block_low,
  input  logic [spnctr_pkg::BYTES_W-1:0]     valid_bytes,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [63:0]                        out_high,
  output logic [63:0]                        out_low,
  output logic [spnctr_pkg::BYTES_W-1:0]     out_bytes
);

  spnctr_pkg::cmd_t    cmd;
  spnctr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  spnctr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  spnctr_datapath #(
    .ROUND_COUNT(ROUND_COUNT),
    .SBOX_SLOTS (SBOX_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .table_address(table_address),
    .table_byte   (table_byte),
    .block_high   (block_high),
    .block_low    (block_low),
    .valid_bytes  (valid_bytes),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_high     (out_high),
    .out_low      (out_low),
    .out_bytes    (out_bytes)
  );

endmodule
